FILE: design/tmba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Texture mip budget admission: shared package
// Widths, limits, format classes, sequencer states and the structs that
// pass between the top level, the sequencer and the level size unit.
// ----------------------------------------------------------------------------
package tmba_pkg;

    localparam int MAX_MIPS   = 15;
    localparam int MAX_SIDE   = 16384;

    localparam int SIDE_W     = 15;
    localparam int MIPS_W     = 4;
    localparam int CLS_W      = 2;
    localparam int BIG_W      = 36;
    localparam int SIZE_W     = 32;
    localparam int PROD_W     = 2 * SIDE_W;

    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 104;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(MAX_SIDE);
    localparam logic [MIPS_W-1:0] MIPS_LIMIT = MIPS_W'(MAX_MIPS);

    localparam logic [CLS_W-1:0] CLS_BLOCK8  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_BLOCK16 = 2'd1;
    localparam logic [CLS_W-1:0] CLS_PIXEL4  = 2'd2;
    localparam logic [CLS_W-1:0] CLS_PIXEL8  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE_MUL,
        ST_SIZE_ACC,
        ST_CHECK,
        ST_SKIP_MUL,
        ST_SKIP_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [SIDE_W-1:0] max_dim;
        logic [SIDE_W-1:0] floor_dim;
        logic [BIG_W-1:0]  budget;
    } cfg_t;

    typedef struct packed {
        logic [SIDE_W-1:0] tex_width;
        logic [SIDE_W-1:0] tex_height;
        logic [MIPS_W-1:0] mip_count;
        logic [CLS_W-1:0]  format_class;
        logic [BIG_W-1:0]  resident_bytes;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [MIPS_W-1:0] first_mip;
        logic [SIDE_W-1:0] out_width;
        logic [SIDE_W-1:0] out_height;
        logic [SIZE_W-1:0] full_bytes;
        logic [SIZE_W-1:0] admitted_bytes;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] height;
        logic [CLS_W-1:0]  cls;
    } lvl_req_t;

    function automatic logic [SIDE_W-1:0] halve_side(input logic [SIDE_W-1:0] side);
        logic [SIDE_W-1:0] h;
        h = side >> 1;
        return (h == '0) ? SIDE_W'(1) : h;
    endfunction

    function automatic logic [SIDE_W-1:0] at_least_one(input logic [SIDE_W-1:0] v);
        return (v == '0) ? SIDE_W'(1) : v;
    endfunction

endpackage
`default_nettype wire

FILE: design/texture_mip_budget_admission.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Texture mip budget admission
// Sizes a texture's mip chain and picks the first level to load so that the
// largest side fits and the remaining chain fits the memory budget.
//
//   Channel  Direction  Payload
//   s_       in         tdata: tex_width, tex_height, mip_count, resident_bytes
//                       tuser: format_class
//   m_       out        tdata: first_mip, out_width, out_height, full_bytes,
//                       admitted_bytes
//   cfg_     in         index 0 max_dimension, 1 floor_dimension, 2 budget_bytes
//
// Each request is sized through the single shared level size multiplier.
// Reset is synchronous and clears the sequencer, the output valid and the
// configuration registers to their defaults.
// A new request is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module texture_mip_budget_admission (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // tex_width[14:0], tex_height[29:15], mip_count[33:30], resident_bytes[69:34]
    input  wire logic [tmba_pkg::S_TDATA_W-1:0] s_tdata,
    // format_class[1:0]
    input  wire logic [tmba_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // first_mip[3:0], out_width[18:4], out_height[33:19], full_bytes[65:34],
    // admitted_bytes[97:66]
    output logic [tmba_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic                          cfg_wen,
    input  wire logic [tmba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tmba_pkg::BIG_W-1:0]    cfg_wdata
);
    import tmba_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    item_t                 item;
    result_t               res;
    logic                  in_ready;
    logic                  res_take;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            case (cfg_index)
                REG_MAX_DIM:   cfg_next.max_dim   = cfg_wdata[SIDE_W-1:0];
                REG_FLOOR_DIM: cfg_next.floor_dim = cfg_wdata[SIDE_W-1:0];
                REG_BUDGET:    cfg_next.budget    = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        item.tex_width      = s_tdata[14:0];
        item.tex_height     = s_tdata[29:15];
        item.mip_count      = s_tdata[33:30];
        item.resident_bytes = s_tdata[69:34];
        item.format_class   = s_tuser[1:0];
    end

    tmba_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_item  (item),
        .in_ready (in_ready),
        .res      (res),
        .res_take (res_take)
    );

    assign s_tready = in_ready;
    assign res_take = res.valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_take) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0, res.admitted_bytes, res.full_bytes,
                             res.out_height, res.out_width, res.first_mip};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_dim   <= SIDE_LIMIT;
            cfg_reg.floor_dim <= SIDE_W'(1);
            cfg_reg.budget    <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer still ready right after a transfer was accepted");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("waiting result dropped or changed before its transfer");

    a_admitted_le_full: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (res.admitted_bytes <= res.full_bytes))
        else $error("admitted size exceeds full chain size");

    a_first_mip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (res.first_mip < MIPS_LIMIT))
        else $error("first admitted mip out of range");

endmodule
`default_nettype wire

FILE: design/tmba_level_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Texture mip budget admission: level size unit
// Computes the byte size of one mip level from its sides and format class
// with one shared multiplier; the product is registered.
// ----------------------------------------------------------------------------
module tmba_level_unit (
    input  wire logic                     aclk,
    input  wire tmba_pkg::lvl_req_t       req,
    output logic [tmba_pkg::SIZE_W-1:0]   level_bytes
);
    import tmba_pkg::*;

    logic [SIDE_W:0]     bw_sum;
    logic [SIDE_W:0]     bh_sum;
    logic [SIDE_W-1:0]   op_a;
    logic [SIDE_W-1:0]   op_b;
    logic [PROD_W-1:0]   prod;
    logic [2:0]          sh;
    logic [SIZE_W-1:0]   bytes_next;
    logic [SIZE_W-1:0]   bytes_reg;

    always_comb begin
        bw_sum = {1'b0, req.width} + (SIDE_W+1)'(3);
        bh_sum = {1'b0, req.height} + (SIDE_W+1)'(3);
        if (req.cls == CLS_BLOCK8 || req.cls == CLS_BLOCK16) begin
            op_a = {1'b0, bw_sum[SIDE_W:2]};
            op_b = {1'b0, bh_sum[SIDE_W:2]};
        end else begin
            op_a = req.width;
            op_b = req.height;
        end
        prod = op_a * op_b;
        case (req.cls)
            CLS_BLOCK8:  sh = 3'd3;
            CLS_BLOCK16: sh = 3'd4;
            CLS_PIXEL4:  sh = 3'd2;
            CLS_PIXEL8:  sh = 3'd3;
            default:     sh = 3'd3;
        endcase
        bytes_next = SIZE_W'(prod) << sh;
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            bytes_reg <= bytes_next;
        end
    end

    assign level_bytes = bytes_reg;

endmodule
`default_nettype wire

FILE: design/tmba_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Texture mip budget admission: sequencer
// Sums the level sizes of the whole chain, then walks the first admitted
// level forward, first to fit the maximum side and then the budget.
// ----------------------------------------------------------------------------
module tmba_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tmba_pkg::cfg_t       cfg,
    input  wire logic                 in_valid,
    input  wire tmba_pkg::item_t      in_item,
    output logic                      in_ready,
    output tmba_pkg::result_t         res,
    input  wire logic                 res_take
);
    import tmba_pkg::*;

    state_t             state_reg, state_next;
    logic [SIDE_W-1:0]  w_reg, w_next;
    logic [SIDE_W-1:0]  h_reg, h_next;
    logic [SIDE_W-1:0]  cw_reg, cw_next;
    logic [SIDE_W-1:0]  ch_reg, ch_next;
    logic [MIPS_W-1:0]  mips_reg, mips_next;
    logic [CLS_W-1:0]   cls_reg, cls_next;
    logic [MIPS_W-1:0]  lvl_reg, lvl_next;
    logic [MIPS_W-1:0]  first_reg, first_next;
    logic [SIZE_W-1:0]  full_reg, full_next;
    logic [SIZE_W-1:0]  prefix_reg, prefix_next;
    logic [BIG_W-1:0]   remain_reg, remain_next;
    logic               budget_phase_reg, budget_phase_next;

    lvl_req_t           req;
    logic [SIZE_W-1:0]  level_bytes;

    logic [SIDE_W-1:0]  in_w, in_h, nw, nh, cur_max, nxt_max;
    logic [MIPS_W-1:0]  in_mips;
    logic               empty_tex, lvl_last, first_last;
    logic               too_big, fits, below_floor;
    logic [SIZE_W-1:0]  need;

    tmba_level_unit u_level (
        .aclk        (aclk),
        .req         (req),
        .level_bytes (level_bytes)
    );

    always_comb begin
        in_w      = (in_item.tex_width  > SIDE_LIMIT) ? SIDE_LIMIT : in_item.tex_width;
        in_h      = (in_item.tex_height > SIDE_LIMIT) ? SIDE_LIMIT : in_item.tex_height;
        in_mips   = (in_item.mip_count  > MIPS_LIMIT) ? MIPS_LIMIT : in_item.mip_count;
        empty_tex = (in_w == '0) || (in_h == '0) || (in_mips == '0);
        nw        = halve_side(cw_reg);
        nh        = halve_side(ch_reg);
        cur_max   = (cw_reg > ch_reg) ? cw_reg : ch_reg;
        nxt_max   = (nw > nh) ? nw : nh;
        lvl_last  = ({1'b0, lvl_reg} + (MIPS_W+1)'(1)) >= {1'b0, mips_reg};
        first_last = ({1'b0, first_reg} + (MIPS_W+1)'(1)) >= {1'b0, mips_reg};
        too_big   = cur_max > at_least_one(cfg.max_dim);
        need      = full_reg - prefix_reg;
        fits      = {{(BIG_W-SIZE_W){1'b0}}, need} <= remain_reg;
        below_floor = nxt_max < at_least_one(cfg.floor_dim);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = empty_tex ? ST_DONE : ST_SIZE_MUL;
                end
            end
            ST_SIZE_MUL: state_next = ST_SIZE_ACC;
            ST_SIZE_ACC: begin
                if (lvl_last) begin
                    state_next = (mips_reg <= MIPS_W'(1)) ? ST_DONE : ST_CHECK;
                end else begin
                    state_next = ST_SIZE_MUL;
                end
            end
            ST_CHECK: begin
                if (first_last) begin
                    state_next = ST_DONE;
                end else if (!budget_phase_reg) begin
                    if (too_big) begin
                        state_next = ST_SKIP_MUL;
                    end else if (cfg.budget == '0) begin
                        state_next = ST_DONE;
                    end
                end else if (fits || below_floor) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SKIP_MUL;
                end
            end
            ST_SKIP_MUL: state_next = ST_SKIP_ACC;
            ST_SKIP_ACC: state_next = ST_CHECK;
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        w_next            = w_reg;
        h_next            = h_reg;
        cw_next           = cw_reg;
        ch_next           = ch_reg;
        mips_next         = mips_reg;
        cls_next          = cls_reg;
        lvl_next          = lvl_reg;
        first_next        = first_reg;
        full_next         = full_reg;
        prefix_next       = prefix_reg;
        remain_next       = remain_reg;
        budget_phase_next = budget_phase_reg;
        req.valid         = 1'b0;
        req.width         = cw_reg;
        req.height        = ch_reg;
        req.cls           = cls_reg;
        in_ready          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    w_next            = in_w;
                    h_next            = in_h;
                    cw_next           = in_w;
                    ch_next           = in_h;
                    mips_next         = in_mips;
                    cls_next          = in_item.format_class;
                    lvl_next          = '0;
                    first_next        = '0;
                    full_next         = '0;
                    prefix_next       = '0;
                    budget_phase_next = 1'b0;
                    remain_next       = (cfg.budget > in_item.resident_bytes) ?
                                        cfg.budget - in_item.resident_bytes : '0;
                end
            end
            ST_SIZE_MUL, ST_SKIP_MUL: begin
                req.valid = 1'b1;
            end
            ST_SIZE_ACC: begin
                full_next = full_reg + level_bytes;
                lvl_next  = lvl_reg + MIPS_W'(1);
                if (lvl_last) begin
                    cw_next = w_reg;
                    ch_next = h_reg;
                end else begin
                    cw_next = nw;
                    ch_next = nh;
                end
            end
            ST_CHECK: begin
                if (!first_last && !budget_phase_reg && !too_big) begin
                    budget_phase_next = 1'b1;
                end
            end
            ST_SKIP_ACC: begin
                prefix_next = prefix_reg + level_bytes;
                first_next  = first_reg + MIPS_W'(1);
                cw_next     = nw;
                ch_next     = nh;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        w_reg            <= w_next;
        h_reg            <= h_next;
        cw_reg           <= cw_next;
        ch_reg           <= ch_next;
        mips_reg         <= mips_next;
        cls_reg          <= cls_next;
        lvl_reg          <= lvl_next;
        first_reg        <= first_next;
        full_reg         <= full_next;
        prefix_reg       <= prefix_next;
        remain_reg       <= remain_next;
        budget_phase_reg <= budget_phase_next;
    end

    always_comb begin
        res.valid          = (state_reg == ST_DONE);
        res.first_mip      = first_reg;
        res.out_width      = cw_reg;
        res.out_height     = ch_reg;
        res.full_bytes     = full_reg;
        res.admitted_bytes = full_reg - prefix_reg;
    end

endmodule
`default_nettype wire

FILE: sim/texture_mip_budget_admission_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Texture mip budget admission: testbench
// Streams texture requests into the block under several register settings and
// idling patterns. Each result transfer is checked, field by field, against a
// prediction of the first admitted mip, its dimensions and the chain sizes.
// ----------------------------------------------------------------------------
module texture_mip_budget_admission_tb;

    import tmba_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_ITEMS  = 32;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [MIPS_W-1:0] first_mip;
        logic [SIDE_W-1:0] out_width;
        logic [SIDE_W-1:0] out_height;
        logic [SIZE_W-1:0] full_bytes;
        logic [SIZE_W-1:0] admitted_bytes;
    } admission_t;

    class admission_scoreboard;
        logic [SIDE_W-1:0] max_dim;
        logic [SIDE_W-1:0] floor_dim;
        logic [BIG_W-1:0]  budget;
        admission_t        expected_admissions[$];
        int                failures;

        function new();
            max_dim   = SIDE_W'(MAX_SIDE);
            floor_dim = SIDE_W'(1);
            budget    = '0;
            failures  = 0;
        endfunction

        function longint unsigned side_at_level(longint unsigned side, longint unsigned level);
            longint unsigned s;
            s = (level < 63) ? (side >> level) : 0;
            return (s == 0) ? 1 : s;
        endfunction

        function longint unsigned chain_bytes(longint unsigned w, longint unsigned h,
                                              longint unsigned levels, logic [CLS_W-1:0] cls);
            longint unsigned total;
            total = 0;
            if (w == 0 || h == 0 || levels == 0) begin
                return 0;
            end
            for (longint unsigned i = 0; i < levels; i++) begin
                case (cls)
                    CLS_BLOCK8:  total += ((w + 3) / 4) * ((h + 3) / 4) * 8;
                    CLS_BLOCK16: total += ((w + 3) / 4) * ((h + 3) / 4) * 16;
                    CLS_PIXEL4:  total += w * h * 4;
                    default:     total += w * h * 8;
                endcase
                w = (w >> 1 == 0) ? 1 : w >> 1;
                h = (h >> 1 == 0) ? 1 : h >> 1;
            end
            return total;
        endfunction

        function logic [SIZE_W-1:0] clip_size(longint unsigned v);
            return (v > 64'hFFFF_FFFF) ? '1 : SIZE_W'(v);
        endfunction

        function admission_t predict_admission(item_t r);
            admission_t      a;
            longint unsigned w, h, mips, first, full, admitted, top, flo, remaining, need;
            w    = (r.tex_width > SIDE_LIMIT) ? MAX_SIDE : r.tex_width;
            h    = (r.tex_height > SIDE_LIMIT) ? MAX_SIDE : r.tex_height;
            mips = (r.mip_count > MIPS_LIMIT) ? MAX_MIPS : r.mip_count;
            full = chain_bytes(w, h, mips, r.format_class);
            admitted = full;
            first = 0;
            a.out_width  = SIDE_W'(w);
            a.out_height = SIDE_W'(h);
            if (w != 0 && h != 0 && mips > 1) begin
                top = (max_dim == 0) ? 1 : max_dim;
                flo = (floor_dim == 0) ? 1 : floor_dim;
                remaining = (budget > r.resident_bytes) ? budget - r.resident_bytes : 0;
                while (first + 1 < mips &&
                       ((side_at_level(w, first) > side_at_level(h, first)) ?
                        side_at_level(w, first) : side_at_level(h, first)) > top) begin
                    first++;
                end
                while (budget != 0 && first + 1 < mips) begin
                    need = chain_bytes(side_at_level(w, first), side_at_level(h, first),
                                       mips - first, r.format_class);
                    if (need <= remaining) begin
                        break;
                    end
                    if (((side_at_level(w, first + 1) > side_at_level(h, first + 1)) ?
                         side_at_level(w, first + 1) : side_at_level(h, first + 1)) < flo) begin
                        break;
                    end
                    first++;
                end
                a.out_width  = SIDE_W'(side_at_level(w, first));
                a.out_height = SIDE_W'(side_at_level(h, first));
                admitted = chain_bytes(side_at_level(w, first), side_at_level(h, first),
                                       mips - first, r.format_class);
            end
            a.first_mip      = MIPS_W'(first);
            a.full_bytes     = clip_size(full);
            a.admitted_bytes = clip_size(admitted);
            return a;
        endfunction

        function void note_request(item_t r);
            expected_admissions.push_back(predict_admission(r));
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_admission(logic [M_TDATA_W-1:0] bus);
            admission_t want;
            if (expected_admissions.size() == 0) begin
                $error("result transfer with no request pending");
                failures++;
                return;
            end
            want = expected_admissions.pop_front();
            compare_field("first_mip", want.first_mip, bus[3:0]);
            compare_field("out_width", want.out_width, bus[18:4]);
            compare_field("out_height", want.out_height, bus[33:19]);
            compare_field("full_bytes", want.full_bytes, bus[65:34]);
            compare_field("admitted_bytes", want.admitted_bytes, bus[97:66]);
        endfunction

        function int pending();
            return expected_admissions.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wen;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [BIG_W-1:0]       cfg_wdata;

    admission_scoreboard sb = new();
    int unsigned         cycle_count = 0;
    int                  gap_pct = 0;
    int                  stall_pct = 0;
    bit                  hold_request = 1'b0;

    texture_mip_budget_admission uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL texture_mip_budget_admission");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_request('{tex_width: s_tdata[14:0], tex_height: s_tdata[29:15],
                                  mip_count: s_tdata[33:30], format_class: s_tuser,
                                  resident_bytes: s_tdata[69:34]});
            end
            if (m_tvalid && m_tready) begin
                sb.check_admission(m_tdata);
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void set_idling(idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin gap_pct = 81; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 81; end
            IDLE_BOTH:     begin gap_pct = 20; stall_pct = 20; end
            default:       begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endfunction

    function automatic item_t make_request(int w, int h, int mips, logic [CLS_W-1:0] cls,
                                           logic [BIG_W-1:0] resident);
        item_t r;
        r.tex_width      = SIDE_W'(w);
        r.tex_height     = SIDE_W'(h);
        r.mip_count      = MIPS_W'(mips);
        r.format_class   = cls;
        r.resident_bytes = resident;
        return r;
    endfunction

    function automatic item_t random_request();
        item_t           r;
        int              pick;
        longint unsigned budget;
        budget = sb.budget;
        pick = $urandom_range(99);
        if (pick < 8) begin
            if ($urandom_range(1) == 1) begin
                r.tex_width  = '0;
                r.tex_height = SIDE_W'($urandom_range(0, 32767));
            end else begin
                r.tex_width  = SIDE_W'($urandom_range(0, 32767));
                r.tex_height = '0;
            end
        end else if (pick < 22) begin
            r.tex_width  = SIDE_W'($urandom_range(0, 32767));
            r.tex_height = SIDE_W'($urandom_range(0, 32767));
        end else if (pick < 50) begin
            r.tex_width  = SIDE_W'(1) << $urandom_range(0, 14);
            r.tex_height = SIDE_W'(1) << $urandom_range(0, 14);
        end else begin
            r.tex_width  = SIDE_W'($urandom_range(1, MAX_SIDE));
            r.tex_height = SIDE_W'($urandom_range(1, MAX_SIDE));
        end
        r.mip_count = ($urandom_range(99) < 85) ? MIPS_W'($urandom_range(2, 15))
                                                : MIPS_W'($urandom_range(0, 1));
        r.format_class = CLS_W'($urandom_range(3));
        pick = $urandom_range(99);
        if (budget != 0 && pick < 70) begin
            r.resident_bytes = BIG_W'((budget * longint'($urandom_range(0, 110))) / 100);
        end else if (pick < 85) begin
            r.resident_bytes = {4'($urandom_range(15)), 32'($urandom)};
        end else begin
            r.resident_bytes = BIG_W'($urandom_range(0, 4095));
        end
        return r;
    endfunction

    task automatic offer_request(input item_t r);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, r.resident_bytes, r.mip_count, r.tex_height, r.tex_width};
        s_tuser  <= r.format_class;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [SIDE_W-1:0] max_dim, input logic [SIDE_W-1:0] floor_dim,
                             input logic [BIG_W-1:0] budget);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_MAX_DIM;
        cfg_wdata <= BIG_W'(max_dim);
        @(posedge aclk);
        cfg_index <= REG_FLOOR_DIM;
        cfg_wdata <= BIG_W'(floor_dim);
        @(posedge aclk);
        cfg_index <= REG_BUDGET;
        cfg_wdata <= budget;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sb.max_dim   = max_dim;
        sb.floor_dim = floor_dim;
        sb.budget    = budget;
    endtask

    logic [SIDE_W-1:0] max_dim_set   [6] = '{15'd0, 15'd32767, 15'd2048, 15'd512, 15'd8192,
                                            15'd16384};
    logic [SIDE_W-1:0] floor_dim_set [6] = '{15'd0, 15'd32767, 15'd64, 15'd4, 15'd2, 15'd1};
    logic [BIG_W-1:0]  budget_set    [6] = '{36'd1, 36'd5000000, 36'd16000000, 36'd1000000,
                                            36'hF_FFFF_FFFF, 36'd0};

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_wen   <= 1'b0;
        cfg_index <= REG_MAX_DIM;
        cfg_wdata <= '0;
        set_idling(IDLE_NONE);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: degenerate sizes, clamping and rounding to blocks.
        offer_request(make_request(0, 0, 5, CLS_BLOCK8, 36'd0));
        offer_request(make_request(0, 100, 4, CLS_PIXEL4, 36'd7));
        offer_request(make_request(100, 0, 15, CLS_BLOCK16, 36'd0));
        offer_request(make_request(64, 64, 0, CLS_PIXEL8, 36'd0));
        offer_request(make_request(64, 64, 1, CLS_PIXEL8, 36'hF_FFFF_FFFF));
        offer_request(make_request(32767, 32767, 15, CLS_PIXEL8, 36'd0));
        offer_request(make_request(16384, 1, 15, CLS_BLOCK8, 36'd0));
        offer_request(make_request(1, 16384, 15, CLS_BLOCK16, 36'd0));
        offer_request(make_request(3, 5, 4, CLS_BLOCK8, 36'd0));
        offer_request(make_request(17, 9, 15, CLS_BLOCK16, 36'd0));
        offer_request(make_request(20000, 300, 15, CLS_PIXEL4, 36'd0));
        drain();

        // Budget pass: fits, partly resident, fully resident, stopped by the floor.
        configure(15'd1024, 15'd8, 36'd64000000);
        offer_request(make_request(4096, 4096, 13, CLS_PIXEL4, 36'd0));
        offer_request(make_request(4096, 4096, 13, CLS_PIXEL4, 36'd60000000));
        offer_request(make_request(4096, 4096, 13, CLS_PIXEL4, 36'd64000000));
        offer_request(make_request(4096, 4096, 13, CLS_PIXEL4, 36'hF_FFFF_FFFF));
        offer_request(make_request(2048, 512, 12, CLS_PIXEL8, 36'd63000000));
        offer_request(make_request(256, 256, 9, CLS_BLOCK8, 36'd63999000));
        offer_request(make_request(8, 8, 4, CLS_BLOCK16, 36'd64000000));
        offer_request(make_request(16384, 16384, 15, CLS_PIXEL8, 36'd0));
        drain();

        // Registers at zero act as one; a budget above the 31-bit range.
        configure(15'd0, 15'd0, 36'd3000000000);
        offer_request(make_request(16384, 16384, 15, CLS_PIXEL8, 36'd0));
        offer_request(make_request(16384, 16384, 15, CLS_PIXEL8, 36'd1000000000));
        offer_request(make_request(5, 7, 2, CLS_BLOCK8, 36'd0));
        drain();

        for (int p = 0; p < 6; p++) begin
            configure(max_dim_set[p], floor_dim_set[p], budget_set[p]);
            for (int m = 0; m < 4; m++) begin
                set_idling(idle_mode_t'(m));
                if (p == 2 && m == 0) begin
                    hold_request = 1'b1;
                end
                for (int i = 0; i < PHASE_ITEMS; i++) begin
                    offer_request(random_request());
                end
            end
            drain();
        end

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASS texture_mip_budget_admission");
        end else begin
            $display("FAIL texture_mip_budget_admission");
        end
        $finish;
    end

endmodule
